@@ hdl/ksst_pkg.sv @@
// shared types, constants and helpers for the keyed sorted score table
// used by ksst_cell and keyed_sorted_score_table; no dependencies
package ksst_pkg;

   // table size and derived widths
   localparam int CAPACITY = 256;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int FIELD_W  = 9;

   // request operation codes
   typedef enum logic [1:0] {
      OP_UPDATE = 2'd0,
      OP_DELETE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   // control sequencer states
   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_APPLY = 1'b1
   } state_type;

   // request word
   typedef struct packed {
      op_type             operation;
      logic [31:0]        account_id;
      logic signed [31:0] score;
   } req_type;

   // response word
   typedef struct packed {
      logic               ok;
      logic [FIELD_W-1:0] rank;
      logic [FIELD_W-1:0] entry_count;
   } rsp_type;

   // one table entry
   typedef struct packed {
      logic [31:0]        id;
      logic signed [31:0] score;
   } entry_type;

   // control broadcast to every cell
   typedef struct packed {
      logic             sample;    // capture compare flags against probe
      entry_type        probe;     // key and score being compared
      logic [CNT_W-1:0] total;     // entries held now
      logic             write;     // update cell contents this cycle
      logic             insert;    // place fresh entry at slot
      logic             remove;    // close the hole at hole position
      logic [IDX_W-1:0] hole;      // position of the matched entry
      logic [IDX_W-1:0] slot;      // insertion position after removal
      entry_type        fresh;     // entry to insert
   } cell_ctl_type;

   // fit a count into a response field
   function automatic logic [FIELD_W-1:0] to_field(input logic [CNT_W-1:0] cnt);
      return FIELD_W'(cnt);
   endfunction

endpackage

@@ hdl/ksst_cell.sv @@
// one cell of the sorted table: holds one entry, compares it, shifts with neighbors
// depends on ksst_pkg
module ksst_cell (
   input  logic                  clock,
   input  logic [ksst_pkg::IDX_W-1:0] cell_index,
   input  ksst_pkg::cell_ctl_type     ctl,
   input  ksst_pkg::entry_type        left_entry,
   input  ksst_pkg::entry_type        right_entry,
   output ksst_pkg::entry_type        entry,
   output logic                  hit,
   output logic                  ge
);
   import ksst_pkg::*;

   entry_type entry_ff, entry_in;
   logic      hit_ff, hit_in;
   logic      ge_ff, ge_in;
   logic      occupied;
   logic      past_hole;
   logic      past_hole_prev;

   // compare against the probe while the word is taken
   always_comb begin
      occupied = CNT_W'(cell_index) < ctl.total;
      hit_in   = occupied && (entry_ff.id == ctl.probe.id);
      ge_in    = occupied && ($signed(entry_ff.score) >= $signed(ctl.probe.score));
   end

   // next contents: keep, take from a neighbor, or take the fresh entry
   always_comb begin
      past_hole      = ctl.remove && (cell_index >= ctl.hole);
      past_hole_prev = ctl.remove && (cell_index > ctl.hole);
      entry_in       = entry_ff;
      if (!ctl.insert) begin
         if (past_hole) begin
            entry_in = right_entry;
         end
      end else if (cell_index < ctl.slot) begin
         if (past_hole) begin
            entry_in = right_entry;
         end
      end else if (cell_index == ctl.slot) begin
         entry_in = ctl.fresh;
      end else begin
         entry_in = past_hole_prev ? entry_ff : left_entry;
      end
   end

   // entry and flag registers
   always_ff @(posedge clock) begin
      if (ctl.write) begin
         entry_ff <= entry_in;
      end
      if (ctl.sample) begin
         hit_ff <= hit_in;
         ge_ff  <= ge_in;
      end
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;
   assign ge    = ge_ff;

endmodule

@@ hdl/keyed_sorted_score_table.sv @@
// keyed sorted score table: a row of CAPACITY cells kept in descending score order.
// response: the word is registered in the apply state that follows the accept cycle.
// flow: the cells compare in the accept cycle and shift in the next, and the sequencer
// takes no new word during that shift, nor while the response register is still full.
// reset: synchronous, empties the table at once (entry count zero), no clearing pass.
// depends on ksst_pkg and ksst_cell
module keyed_sorted_score_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ksst_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ksst_pkg::rsp_type rsp_word
);
   import ksst_pkg::*;

   state_type         state_ff, state_in;
   req_type           req_ff;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic              accept;

   cell_ctl_type      ctl;
   entry_type         cell_entry [CAPACITY];
   logic [CAPACITY-1:0] hit;
   logic [CAPACITY-1:0] ge;

   logic              found;
   logic              ge_at_hit;
   logic [IDX_W-1:0]  hole;
   logic [CNT_W-1:0]  ge_count;
   logic [CNT_W-1:0]  slot;
   logic              prev_ge;
   logic              refuse;

   // take a word only when idle and the response register is free
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      if (i == 0) begin : g_first
         assign left_entry = '0;
      end else begin : g_left
         assign left_entry = cell_entry[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_right
         assign right_entry = cell_entry[i+1];
      end
      ksst_cell u_cell (
         .clock       (clock),
         .cell_index  (IDX_W'(i)),
         .ctl         (ctl),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .hit         (hit[i]),
         .ge          (ge[i])
      );
   end

   // position of the matching cell and of the score boundary
   always_comb begin
      found     = 1'b0;
      ge_at_hit = 1'b0;
      hole      = '0;
      ge_count  = '0;
      prev_ge   = 1'b1;
      for (int i = 0; i < CAPACITY; i++) begin
         found     = found | hit[i];
         ge_at_hit = ge_at_hit | (hit[i] & ge[i]);
         if (hit[i]) begin
            hole = hole | IDX_W'(i);
         end
         // boundary where the ge flags fall from one to zero
         if (prev_ge && !ge[i]) begin
            ge_count = ge_count | CNT_W'(i);
         end
         prev_ge = ge[i];
      end
      if (ge[CAPACITY-1]) begin
         ge_count = ge_count | CNT_W'(CAPACITY);
      end
      slot   = ge_count - CNT_W'(ge_at_hit);
      refuse = !found && (total_ff >= CNT_W'(CAPACITY));
   end

   // sequencer: next state, cell control and response
   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      ctl          = '0;
      ctl.sample   = accept;
      ctl.probe.id    = req_word.account_id;
      ctl.probe.score = req_word.score;
      ctl.total    = total_ff;
      ctl.hole     = hole;
      ctl.slot     = IDX_W'(slot);
      ctl.fresh.id    = req_ff.account_id;
      ctl.fresh.score = req_ff.score;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in       = ST_IDLE;
            rsp_valid_in   = 1'b1;
            rsp_in.ok      = 1'b0;
            rsp_in.rank    = '0;
            case (req_ff.operation)
               OP_UPDATE: begin
                  if (!refuse) begin
                     ctl.write   = 1'b1;
                     ctl.insert  = 1'b1;
                     ctl.remove  = found;
                     total_in    = total_ff + CNT_W'(!found);
                     rsp_in.ok   = 1'b1;
                     rsp_in.rank = to_field(slot + CNT_W'(1));
                  end
               end
               OP_DELETE: begin
                  if (found) begin
                     ctl.write  = 1'b1;
                     ctl.remove = 1'b1;
                     total_in   = total_ff - CNT_W'(1);
                     rsp_in.ok  = 1'b1;
                  end
               end
               OP_QUERY: begin
                  if (found) begin
                     rsp_in.ok   = 1'b1;
                     rsp_in.rank = to_field(CNT_W'(hole) + CNT_W'(1));
                  end
               end
               OP_CLEAR: begin
                  total_in  = '0;
                  rsp_in.ok = 1'b1;
               end
               default: begin
                  rsp_in.ok = 1'b0;
               end
            endcase
            rsp_in.entry_count = to_field(total_in);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_word;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
